[design/grm_pkg.sv]
// Shared types, constants and the quadrant sine/cosine tables for the grid ray marcher.
// No dependencies; every other design file imports this package.

package grm_pkg;

    // Map geometry and angle resolution
    localparam int MAP_DIM     = 8;
    localparam int ANGLE_STEPS = 1024;

    localparam int CELL_COUNT = MAP_DIM * MAP_DIM;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int CELL_BITS  = $clog2(MAP_DIM);
    localparam int ANGLE_BITS = $clog2(ANGLE_STEPS);
    localparam int QUAD       = ANGLE_STEPS / 4;
    localparam int QUAD_BITS  = ANGLE_BITS - 2;

    // Field widths
    localparam int POS_W   = 15;
    localparam int DIR_W   = 10;
    localparam int IDX_W   = 6;
    localparam int KIND_W  = 2;
    localparam int LIMIT_W = 10;
    localparam int LEN_W   = 12;

    // Fixed-point formats: trig is Q1.14, positions Q3.12, march sums Q26
    localparam int TRIG_FRAC = 14;
    localparam int TAB_W     = 15;
    localparam int TRIG_W    = 16;
    localparam int DX_W      = 29;
    localparam int ACC_W     = 39;
    localparam int FRAC_W    = 26;

    // Register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_STEP_LIMIT  = 1'b0;
    localparam logic REG_STEP_LENGTH = 1'b1;
    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RST  = LIMIT_W'(400);
    localparam logic [LEN_W-1:0]   STEP_LENGTH_RST = LEN_W'(205);

    // Item opcodes and special cell contents
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_EDGE  = KIND_W'(1);

    // Map access from the marcher to the cell store
    typedef struct packed {
        logic               wr_en;
        logic [CELL_AW-1:0] wr_addr;
        logic [KIND_W-1:0]  wr_data;
        logic               rd_en;
        logic [CELL_AW-1:0] rd_addr;
    } t_map_req;

    typedef logic [TAB_W-1:0] t_trig_tab [0:QUAD-1];

    // Unsigned quotient by shift and subtract, used only while building tables
    function automatic longint f_udiv(input longint num, input longint den);
        longint rem;
        longint quo;
        int     b;
        rem = num;
        quo = 0;
        for (b = 40; b >= 0; b--) begin
            if ((rem >>> b) >= den) begin
                rem = rem - (den <<< b);
                quo = quo | (64'sd1 <<< b);
            end
        end
        return quo;
    endfunction

    // Build the quadrant table at elaboration: Taylor series in Q28 with
    // truncated products, clamped at zero, rounded half up to Q14.
    function automatic t_trig_tab f_build_tab(input bit want_sin);
        t_trig_tab tab;
        longint    a;
        longint    ts;
        longint    tc;
        longint    s;
        longint    c;
        longint    one;
        longint    half_pi;
        int        j;
        int        k;
        one     = 64'sd1 <<< 28;
        half_pi = 64'sd421657428;
        for (j = 0; j < QUAD; j++) begin
            a  = (half_pi * longint'(4 * j)) >>> ANGLE_BITS;
            ts = a;
            tc = one;
            s  = a;
            c  = one;
            for (k = 1; k <= 7; k++) begin
                ts = (ts * a) >>> 28;
                ts = (ts * a) >>> 28;
                ts = f_udiv(ts, longint'((2 * k) * (2 * k + 1)));
                tc = (tc * a) >>> 28;
                tc = (tc * a) >>> 28;
                tc = f_udiv(tc, longint'((2 * k - 1) * (2 * k)));
                if ((k & 1) == 1) begin
                    s = s - ts;
                    c = c - tc;
                end else begin
                    s = s + ts;
                    c = c + tc;
                end
            end
            if (s < 0) s = 0;
            if (c < 0) c = 0;
            s = (s + 64'sd8192) >>> 14;
            c = (c + 64'sd8192) >>> 14;
            tab[j] = want_sin ? TAB_W'(s) : TAB_W'(c);
        end
        return tab;
    endfunction

    localparam t_trig_tab SIN_TAB = f_build_tab(1'b1);
    localparam t_trig_tab COS_TAB = f_build_tab(1'b0);

endpackage

[design/grid_ray_march.sv]
// Grid ray marcher: casts rays through a MAP_DIM x MAP_DIM cell map in fixed steps.
//
// Usage:
// - Input channel (i_valid/o_ready): op 0 writes one map cell and is done in the
//   accept cycle; op 1 casts a ray from (pos_x, pos_y) along direction.
// - Output channel (o_valid/i_ready): one item per ray with steps_taken, wall_kind
//   and hit. Cell writes give no item.
// - A ray ends at the step where it hits, at most at step_limit, and its result
//   then goes to o_valid. The setup states S_TRIG, S_MULT and S_INIT do the table
//   lookup, the step delta multiply and the first advance; then one step is issued
//   per cycle (a map read when on the map) while the previous step is checked.
// - One ray is in flight at a time; o_ready is high only between rays, so a new ray
//   is not taken before the last one is done. A new item is taken while a finished
//   result still waits in the output register.
// - If the receiver stalls, a second finished ray waits inside until taken.
// - Reset empties the map (per-cell valid bits), restores step_limit = 400 and
//   step_length = 205, and drops any pending item. No clearing pass is needed.
// - APB registers: 0x0 step_limit, 0x4 step_length; write only while idle.
// Depends on grm_pkg, grm_map_ram and grm_marcher.

module grid_ray_march (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [grm_pkg::POS_W-1:0]     i_pos_x,
    input  logic [grm_pkg::POS_W-1:0]     i_pos_y,
    input  logic [grm_pkg::DIR_W-1:0]     i_direction,
    input  logic [grm_pkg::IDX_W-1:0]     i_cell_index,
    input  logic [grm_pkg::KIND_W-1:0]    i_cell_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [grm_pkg::LIMIT_W-1:0]   o_steps_taken,
    output logic [grm_pkg::KIND_W-1:0]    o_wall_kind,
    output logic                          o_hit,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [grm_pkg::APB_AW-1:0]    paddr,
    input  logic [grm_pkg::APB_DW-1:0]    pwdata,
    output logic [grm_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import grm_pkg::*;

    logic [LIMIT_W-1:0] r_step_limit;
    logic [LEN_W-1:0]   r_step_length;
    logic               cfg_wr;
    logic               reg_sel;
    t_map_req           map_req;
    logic [KIND_W-1:0]  map_rd_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit  <= STEP_LIMIT_RST;
            r_step_length <= STEP_LENGTH_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_STEP_LIMIT:  r_step_limit  <= pwdata[LIMIT_W-1:0];
                REG_STEP_LENGTH: r_step_length <= pwdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Return register contents on reads
    always_comb begin
        case (reg_sel)
            REG_STEP_LIMIT:  prdata = APB_DW'(r_step_limit);
            REG_STEP_LENGTH: prdata = APB_DW'(r_step_length);
            default:         prdata = '0;
        endcase
    end

    grm_map_ram u_map_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_rd_data)
    );

    grm_marcher u_marcher (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_direction   (i_direction),
        .i_cell_index  (i_cell_index),
        .i_cell_value  (i_cell_value),
        .i_step_limit  (r_step_limit),
        .i_step_length (r_step_length),
        .o_map_req     (map_req),
        .i_rd_data     (map_rd_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_steps_taken (o_steps_taken),
        .o_wall_kind   (o_wall_kind),
        .o_hit         (o_hit)
    );

`ifndef ASSERT_OFF
    // A miss reports the full step budget and the edge kind
    a_miss_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_wall_kind == KIND_EDGE && o_steps_taken == r_step_limit))
        else $error("miss result does not match step limit");

    // A hit lands on a non-empty cell within the step budget
    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (o_wall_kind != KIND_EMPTY && o_steps_taken != '0
                                && o_steps_taken <= r_step_limit))
        else $error("hit result out of range");

    // Reset drops any pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
`endif

endmodule

[design/grm_map_ram.sv]
// Map cell store: one write port and one registered read port, with per-cell valid bits.
// Depends on grm_pkg (t_map_req, CELL_COUNT, KIND_W).

module grm_map_ram (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  grm_pkg::t_map_req         i_req,
    output logic [grm_pkg::KIND_W-1:0] o_rd_data
);
    import grm_pkg::*;

    logic [KIND_W-1:0]   r_mem [0:CELL_COUNT-1];
    logic [CELL_COUNT-1:0] r_vld;
    logic [KIND_W-1:0]   r_rd_data;
    logic                r_rd_vld;

    // Write the cell array and register the read data; no reset on the payload
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // Track written cells so an unwritten cell reads as empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : KIND_EMPTY;

endmodule

[design/grm_marcher.sv]
// Ray march sequencer: trig lookup, step delta multiply, and a two-stage
// address/check loop over the map store, plus the result register.
// Depends on grm_pkg (tables, formats, t_map_req).

module grm_marcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_op,
    input  logic [grm_pkg::POS_W-1:0]     i_pos_x,
    input  logic [grm_pkg::POS_W-1:0]     i_pos_y,
    input  logic [grm_pkg::DIR_W-1:0]     i_direction,
    input  logic [grm_pkg::IDX_W-1:0]     i_cell_index,
    input  logic [grm_pkg::KIND_W-1:0]    i_cell_value,
    input  logic [grm_pkg::LIMIT_W-1:0]   i_step_limit,
    input  logic [grm_pkg::LEN_W-1:0]     i_step_length,
    output grm_pkg::t_map_req             o_map_req,
    input  logic [grm_pkg::KIND_W-1:0]    i_rd_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [grm_pkg::LIMIT_W-1:0]   o_steps_taken,
    output logic [grm_pkg::KIND_W-1:0]    o_wall_kind,
    output logic                          o_hit
);
    import grm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TRIG,
        S_MULT,
        S_INIT,
        S_MARCH,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 outside;
        logic [CELL_BITS-1:0] coord;
    } t_cell;

    localparam logic [1:0] QD_FIRST  = 2'd0;
    localparam logic [1:0] QD_SECOND = 2'd1;
    localparam logic [1:0] QD_THIRD  = 2'd2;
    localparam logic [1:0] QD_FOURTH = 2'd3;

    localparam logic signed [ACC_W-1:0] CELL_ONE   = ACC_W'(64'sd1 <<< FRAC_W);
    localparam logic signed [ACC_W-1:0] NEG_CELL   = -CELL_ONE;
    localparam logic signed [ACC_W-1:0] CELL_LIMIT = ACC_W'(longint'(MAP_DIM) <<< FRAC_W);

    // Truncate a Q26 coordinate toward zero to a cell, flag points off the map
    function automatic t_cell f_to_cell(input logic signed [ACC_W-1:0] p);
        t_cell res;
        res.outside = 1'b0;
        res.coord   = '0;
        if (p <= NEG_CELL) begin
            res.outside = 1'b1;
        end else if (p < 0) begin
            res.coord = '0;
        end else if (p >= CELL_LIMIT) begin
            res.outside = 1'b1;
        end else begin
            res.coord = p[FRAC_W +: CELL_BITS];
        end
        return res;
    endfunction

    t_state                     r_state;
    logic [ANGLE_BITS-1:0]      r_dir;
    logic signed [TRIG_W-1:0]   r_cos;
    logic signed [TRIG_W-1:0]   r_sin;
    logic signed [DX_W-1:0]     r_dx;
    logic signed [DX_W-1:0]     r_dy;
    logic signed [ACC_W-1:0]    r_acc_x;
    logic signed [ACC_W-1:0]    r_acc_y;
    logic [LIMIT_W:0]           r_issue_k;
    logic                       r_chk_vld;
    logic [LIMIT_W-1:0]         r_chk_k;
    logic                       r_chk_out;
    logic [LIMIT_W-1:0]         r_res_steps;
    logic [KIND_W-1:0]          r_res_kind;
    logic                       r_res_hit;
    logic                       r_out_valid;
    logic [LIMIT_W-1:0]         r_steps;
    logic [KIND_W-1:0]          r_kind;
    logic                       r_hit;

    t_cell                      cur_x;
    t_cell                      cur_y;
    logic                       step_out;
    logic                       issue_ok;
    logic [KIND_W-1:0]          chk_kind;
    logic                       chk_hit;
    logic                       chk_last;
    logic                       out_free;
    logic                       in_take;
    logic [1:0]                 quadrant;
    logic [QUAD_BITS-1:0]       tab_idx;
    logic signed [TRIG_W-1:0]   tab_s;
    logic signed [TRIG_W-1:0]   tab_c;
    logic signed [DX_W-1:0]     len_s;
    logic signed [ACC_W-1:0]    n_acc_x;
    logic signed [ACC_W-1:0]    n_acc_y;

    // Decode the current march point and the check stage
    always_comb begin
        cur_x    = f_to_cell(r_acc_x);
        cur_y    = f_to_cell(r_acc_y);
        step_out = cur_x.outside | cur_y.outside;
        issue_ok = (r_issue_k <= {1'b0, i_step_limit});
        chk_kind = r_chk_out ? KIND_EDGE : i_rd_data;
        chk_hit  = r_chk_vld && (chk_kind != KIND_EMPTY);
        chk_last = r_chk_vld && (r_chk_k == i_step_limit);
        out_free = !r_out_valid || i_ready;
        in_take  = i_valid && (r_state == S_IDLE);
        quadrant = r_dir[ANGLE_BITS-1 -: 2];
        tab_idx  = r_dir[QUAD_BITS-1:0];
        tab_s    = $signed({1'b0, SIN_TAB[tab_idx]});
        tab_c    = $signed({1'b0, COS_TAB[tab_idx]});
        len_s    = DX_W'($signed({1'b0, i_step_length}));
        n_acc_x  = r_acc_x + ACC_W'(r_dx);
        n_acc_y  = r_acc_y + ACC_W'(r_dy);
    end

    // Drive map writes from cell items and reads from the march loop
    always_comb begin
        o_map_req.wr_en   = in_take && (i_op == OP_WRITE) && (int'(i_cell_index) < CELL_COUNT);
        o_map_req.wr_addr = CELL_AW'(i_cell_index);
        o_map_req.wr_data = i_cell_value;
        o_map_req.rd_en   = (r_state == S_MARCH) && !chk_hit && !chk_last && issue_ok
                            && !step_out;
        o_map_req.rd_addr = CELL_AW'(int'(cur_y.coord) * MAP_DIM + int'(cur_x.coord));
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
        end else begin
            // Drop a taken result unless the next one loads this cycle
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take && (i_op == OP_CAST)) begin
                        r_dir   <= ANGLE_BITS'(i_direction);
                        r_acc_x <= ACC_W'({i_pos_x, {TRIG_FRAC{1'b0}}});
                        r_acc_y <= ACC_W'({i_pos_y, {TRIG_FRAC{1'b0}}});
                        r_state <= S_TRIG;
                    end
                end
                S_TRIG: begin
                    // Map the quadrant offset back onto the full circle
                    case (quadrant)
                        QD_FIRST: begin
                            r_cos <= tab_c;
                            r_sin <= tab_s;
                        end
                        QD_SECOND: begin
                            r_cos <= -tab_s;
                            r_sin <= tab_c;
                        end
                        QD_THIRD: begin
                            r_cos <= -tab_c;
                            r_sin <= -tab_s;
                        end
                        QD_FOURTH: begin
                            r_cos <= tab_s;
                            r_sin <= -tab_c;
                        end
                        default: begin
                            r_cos <= tab_c;
                            r_sin <= tab_s;
                        end
                    endcase
                    r_state <= S_MULT;
                end
                S_MULT: begin
                    r_dx    <= DX_W'(r_cos) * len_s;
                    r_dy    <= DX_W'(r_sin) * len_s;
                    r_state <= S_INIT;
                end
                S_INIT: begin
                    // Advance to the first step point
                    r_acc_x   <= n_acc_x;
                    r_acc_y   <= n_acc_y;
                    r_issue_k <= (LIMIT_W + 1)'(1);
                    r_chk_vld <= 1'b0;
                    if (i_step_limit == '0) begin
                        r_res_steps <= '0;
                        r_res_kind  <= KIND_EDGE;
                        r_res_hit   <= 1'b0;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_MARCH;
                    end
                end
                S_MARCH: begin
                    if (chk_hit) begin
                        r_res_steps <= r_chk_k;
                        r_res_kind  <= chk_kind;
                        r_res_hit   <= 1'b1;
                        r_chk_vld   <= 1'b0;
                        r_state     <= S_DONE;
                    end else if (chk_last) begin
                        r_res_steps <= r_chk_k;
                        r_res_kind  <= KIND_EDGE;
                        r_res_hit   <= 1'b0;
                        r_chk_vld   <= 1'b0;
                        r_state     <= S_DONE;
                    end else if (issue_ok) begin
                        // Hand this step to the check stage and advance
                        r_chk_vld <= 1'b1;
                        r_chk_k   <= r_issue_k[LIMIT_W-1:0];
                        r_chk_out <= step_out;
                        r_acc_x   <= n_acc_x;
                        r_acc_y   <= n_acc_y;
                        r_issue_k <= r_issue_k + 1'b1;
                    end else begin
                        r_chk_vld <= 1'b0;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_steps     <= r_res_steps;
                        r_kind      <= r_res_kind;
                        r_hit       <= r_res_hit;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_steps_taken = r_steps;
    assign o_wall_kind   = r_kind;
    assign o_hit         = r_hit;

endmodule
